>>> src/assert_macros.svh
// Assertion macros shared by the RTL. Each macro expects signals named clk and rst_n
// to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define ASSERT_IMP(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
// Condition a implies condition b in the next cycle.
`define ASSERT_NEXT(label, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`else
`define ASSERT_IMP(label, a, b, msg)
`define ASSERT_NEXT(label, a, b, msg)
`endif
`endif

>>> src/stfs_pkg.sv
`default_nettype none
package stfs_pkg;

    // Request codes carried on req_type.
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_GROW  = 3'b010,
        ST_PROBE = 3'b100
    } state_t;

    localparam int KEY_W   = 32;
    localparam int POS_W   = 6;
    localparam int PROBE_W = 4;
    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;

    // Control handed to one cell of the key chain.
    typedef struct packed {
        logic load;     // sorted insert happens this cycle
        logic valid;    // cell index is below the entry count
        logic at_end;   // cell index equals the entry count
        logic prev_gt;  // left neighbor holds a valid key above the new key
    } cell_ctl_t;

    // Compare status reported by one cell.
    typedef struct packed {
        logic gt;       // valid and stored key greater than the bus key
        logic lt;       // stored key less than the bus key
        logic eq;       // stored key equal to the bus key
    } cell_stat_t;

endpackage
`default_nettype wire

>>> src/stfs_cell.sv
`default_nettype none
module stfs_cell
    import stfs_pkg::*;
(
    input  wire logic                     clk,
    input  wire cell_ctl_t                ctl,
    input  wire logic signed [KEY_W-1:0]  bus_key,
    input  wire logic signed [KEY_W-1:0]  prev_key,
    output logic signed [KEY_W-1:0]       cell_key,
    output cell_stat_t                    stat
);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    assign cell_key = key_reg;
    assign stat.gt  = ctl.valid && (key_reg > bus_key);
    assign stat.lt  = key_reg < bus_key;
    assign stat.eq  = key_reg == bus_key;

    // On insert, a cell whose left neighbor is larger takes the neighbor's key; the
    // first larger cell, or the first free cell, takes the new key.
    always_comb
    begin
        key_next = key_reg;
        if (ctl.load)
        begin
            if (ctl.prev_gt)
                key_next = prev_key;
            else if (stat.gt || ctl.at_end)
                key_next = bus_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
`default_nettype wire

>>> src/sorted_table_fibonacci_search.sv
`default_nettype none
// Channel   Signals                              Handshake
// -------   ----------------------------------   ---------------------------------
// request   start, req_type, key                 transfer when start && !busy
// result    done, found, position, probe_count,  transfer on each cycle done is high
//           full_error
//
// Clear, append and unused codes, and a search of an empty table, show their result
// in the cycle after the transfer and busy never rises, so a new request may follow
// at once. A search with entries first takes Fibonacci growth steps until a term
// reaches the entry count, then probes the registered compare vectors; it ends as
// soon as the key turns up inside the probe loop, and otherwise with a closing step
// at offset plus one, taken whether or not it compares. rst_n clears the entry
// count and the sequencer at once.
// The result receiver cannot stall: each result is valid for one cycle only.
module sorted_table_fibonacci_search
    import stfs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                req_type,
    input  wire logic signed [KEY_W-1:0]   key,
    output logic                           done,
    output logic                           found,
    output logic [POS_W-1:0]               position,
    output logic [PROBE_W-1:0]             probe_count,
    output logic                           full_error
);

    `include "assert_macros.svh"

    // Count width holds TABLE_DEPTH itself; index width addresses one entry.
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // Fibonacci terms stay below twice the count; the probe sum below three times it.
    localparam int FW = CW + 1;
    localparam int SW = CW + 2;

    // The key chain: every cell holds one sorted entry and compares it to the bus key.
    logic signed [KEY_W-1:0] cell_key [TABLE_DEPTH];
    cell_stat_t              cell_stat [TABLE_DEPTH];
    cell_ctl_t               cell_ctl [TABLE_DEPTH];

    logic [CW-1:0] count_reg, count_next;
    logic          accept;
    logic          table_full;

    assign accept     = start && !busy;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++)
        begin : g_cell
            assign cell_ctl[k].load   = accept && (req_t'(req_type) == REQ_APPEND)
                                        && !table_full;
            assign cell_ctl[k].valid  = CW'(k) < count_reg;
            assign cell_ctl[k].at_end = CW'(k) == count_reg;
            if (k == 0)
            begin : g_first
                assign cell_ctl[k].prev_gt = 1'b0;
                stfs_cell u_cell (
                    .clk      (clk),
                    .ctl      (cell_ctl[k]),
                    .bus_key  (key),
                    .prev_key (key),
                    .cell_key (cell_key[k]),
                    .stat     (cell_stat[k])
                );
            end
            else
            begin : g_rest
                assign cell_ctl[k].prev_gt = cell_stat[k-1].gt;
                stfs_cell u_cell (
                    .clk      (clk),
                    .ctl      (cell_ctl[k]),
                    .bus_key  (key),
                    .prev_key (cell_key[k-1]),
                    .cell_key (cell_key[k]),
                    .stat     (cell_stat[k])
                );
            end
        end
    endgenerate

    // The search works on snapshots of the per-cell compare flags taken at the
    // transfer, so each probe is a single bit selection.
    logic [TABLE_DEPTH-1:0] lt_vec, eq_vec;
    logic [TABLE_DEPTH-1:0] lt_reg, lt_next;
    logic [TABLE_DEPTH-1:0] eq_reg, eq_next;

    always_comb
    begin
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            lt_vec[j] = cell_stat[j].lt;
            eq_vec[j] = cell_stat[j].eq;
        end
    end

    state_t             state_reg, state_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [FW-1:0]      f_reg, f_next;
    logic [FW-1:0]      f1_reg, f1_next;
    logic [FW-1:0]      f2_reg, f2_next;
    logic [CW-1:0]      op1_reg, op1_next;   // search offset plus one
    logic [PROBE_W-1:0] pc_reg, pc_next;

    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PROBE_W-1:0] probes_reg, probes_next;
    logic               full_reg, full_next;

    logic [SW-1:0]      probe_sum;
    logic [SW-1:0]      idx_wide;
    logic [IW-1:0]      idx;
    logic [IW-1:0]      op1_idx;
    logic [PROBE_W-1:0] pc_inc;

    // Probe index is offset + F(m-2), clamped into the valid range.
    assign probe_sum = SW'(op1_reg) + SW'(f2_reg);
    always_comb
    begin
        if (probe_sum > SW'(n_reg))
            idx_wide = SW'(n_reg) - SW'(1);
        else if (probe_sum == '0)
            idx_wide = '0;
        else
            idx_wide = probe_sum - SW'(1);
    end
    assign idx     = idx_wide[IW-1:0];
    assign op1_idx = op1_reg[IW-1:0];
    assign pc_inc  = (pc_reg == PROBE_MAX) ? PROBE_MAX : pc_reg + PROBE_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        f_next      = f_reg;
        f1_next     = f1_reg;
        f2_next     = f2_reg;
        op1_next    = op1_reg;
        pc_next     = pc_reg;
        lt_next     = lt_reg;
        eq_next     = eq_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        pos_next    = pos_reg;
        probes_next = probes_reg;
        full_next   = full_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next  = 1'b0;
                    pos_next    = '0;
                    probes_next = '0;
                    full_next   = 1'b0;
                    case (req_t'(req_type))
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        REQ_APPEND:
                        begin
                            if (table_full)
                                full_next = 1'b1;
                            else
                                count_next = count_reg + CW'(1);
                            done_next = 1'b1;
                        end
                        REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                                done_next = 1'b1;
                            else
                            begin
                                n_next     = count_reg;
                                lt_next    = lt_vec;
                                eq_next    = eq_vec;
                                f2_next    = '0;
                                f1_next    = FW'(1);
                                f_next     = FW'(1);
                                op1_next   = '0;
                                pc_next    = '0;
                                state_next = ST_GROW;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_GROW:
            begin
                // Step up to the smallest Fibonacci number not below the count.
                if (f_reg < FW'(n_reg))
                begin
                    f2_next = f1_reg;
                    f1_next = f_reg;
                    f_next  = f1_reg + f_reg;
                end
                else
                    state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                if (f_reg > FW'(1))
                begin
                    pc_next = pc_inc;
                    if (lt_reg[idx])
                    begin
                        f_next   = f1_reg;
                        f1_next  = f2_reg;
                        f2_next  = f1_reg - f2_reg;
                        op1_next = CW'(idx) + CW'(1);
                    end
                    else if (!eq_reg[idx])
                    begin
                        f_next  = f2_reg;
                        f1_next = f1_reg - f2_reg;
                        f2_next = f2_reg - (f1_reg - f2_reg);
                    end
                    else
                    begin
                        found_next  = 1'b1;
                        pos_next    = POS_W'(idx);
                        probes_next = pc_inc;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    // Last check of the entry just past the offset, if it exists.
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if ((f1_reg == FW'(1)) && (op1_reg < n_reg))
                    begin
                        probes_next = pc_inc;
                        if (eq_reg[op1_idx])
                        begin
                            found_next = 1'b1;
                            pos_next   = POS_W'(op1_idx);
                        end
                    end
                    else
                        probes_next = pc_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        f_reg      <= f_next;
        f1_reg     <= f1_next;
        f2_reg     <= f2_next;
        op1_reg    <= op1_next;
        pc_reg     <= pc_next;
        lt_reg     <= lt_next;
        eq_reg     <= eq_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        probes_reg <= probes_next;
        full_reg   <= full_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign position    = pos_reg;
    assign probe_count = probes_reg;
    assign full_error  = full_reg;

    // A search over a non-empty table must occupy the sequencer.
    `ASSERT_NEXT(a_search_busy, accept && (req_type == REQ_SEARCH) && (count_reg != '0),
                 busy, "search did not start the sequencer")
    // A found key always cost at least one comparison and is never a dropped append.
    `ASSERT_IMP(a_found_probed, done && found, (probe_count != '0) && !full_error,
                "found result without a probe")
    // The entry count never passes the table depth.
    `ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(TABLE_DEPTH), "entry count exceeds depth")

endmodule
`default_nettype wire
